/* design/dsws_pkg.sv */
package dsws_pkg;

  localparam int unsigned STACK_WORDS = 1024;
  localparam int unsigned ENTRY_BITS  = 32;

  // operation codes
  localparam logic [4:0] OP_PUSH      = 5'd0;
  localparam logic [4:0] OP_POP       = 5'd1;
  localparam logic [4:0] OP_DROP      = 5'd2;
  localparam logic [4:0] OP_REMOVE    = 5'd3;
  localparam logic [4:0] OP_PEEK      = 5'd4;
  localparam logic [4:0] OP_OVERWRITE = 5'd5;
  localparam logic [4:0] OP_CLEAR     = 5'd6;
  localparam logic [4:0] OP_DEPTH     = 5'd7;
  localparam logic [4:0] OP_PROTECT   = 5'd8;
  localparam logic [4:0] OP_UNPROTECT = 5'd9;
  localparam logic [4:0] OP_SNAP_FULL = 5'd10;
  localparam logic [4:0] OP_SNAP_KEEP = 5'd11;
  localparam logic [4:0] OP_SNAP_HIDE = 5'd12;
  localparam logic [4:0] OP_SNAP_CLR  = 5'd13;
  localparam logic [4:0] OP_RESTORE   = 5'd14;
  localparam logic [4:0] OP_REVERT    = 5'd15;
  localparam logic [4:0] OP_SNAP_REM  = 5'd16;
  localparam logic [4:0] OP_DROP_CUR  = 5'd17;
  localparam logic [4:0] OP_SNAP_CNT  = 5'd18;
  localparam logic [4:0] OP_SNAP_DEP  = 5'd19;
  localparam logic [4:0] OP_SNAP_PEEK = 5'd20;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_BADSNAP = 3'd3;
  localparam logic [2:0] ST_PROT    = 3'd4;
  localparam logic [2:0] ST_RANGE   = 3'd5;

  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] value;
    logic [9:0]  level;
    logic [9:0]  count;
    logic [9:0]  snapshot;
  } dsws_in_t;

  typedef struct packed {
    logic [31:0] data;
    logic [10:0] depth;
    logic [2:0]  status;
  } dsws_out_t;

endpackage

/* design/dsws_mem.sv */
module dsws_mem #(
  parameter int unsigned DEPTH = dsws_pkg::STACK_WORDS,
  parameter int unsigned WIDTH = dsws_pkg::ENTRY_BITS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dsws_ctrl.sv */
module dsws_ctrl #(
  parameter int unsigned STACK_WORDS = dsws_pkg::STACK_WORDS,
  parameter int unsigned ENTRY_BITS  = dsws_pkg::ENTRY_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  dsws_pkg::dsws_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output dsws_pkg::dsws_out_t            out_data_o,
  output logic                           mem_we_o,
  output logic                           mem_re_o,
  output logic [$clog2(STACK_WORDS)-1:0] mem_addr_o,
  output logic [ENTRY_BITS-1:0]          mem_wdata_o,
  input  logic [ENTRY_BITS-1:0]          mem_rdata_i
);

  localparam int unsigned AW = $clog2(STACK_WORDS);
  localparam int unsigned IW = AW + 1;
  localparam int unsigned XW = ((IW > 10) ? IW : 10) + 2;
  localparam int unsigned CW = (ENTRY_BITS > XW) ? ENTRY_BITS : XW;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_RDWAIT, S_RD17, S_WALK_RD, S_WALK_CHK, S_WEND,
    S_FOUND, S_REMOVE, S_CP_RD, S_CP_WR, S_MARK, S_POST, S_DONE
  } state_e;

  state_e            state_q;
  logic [4:0]        op_q;
  logic [ENTRY_BITS-1:0] val_q, data_q;
  logic [9:0]        lvl_q, cnt_q, snp_q;
  logic [IW-1:0]     top_q, bot_q, flr_q;
  logic [IW-1:0]     p_q, prev_q, i_q, m_q;
  logic [IW-1:0]     src_q, dst_q, len_q, dep_q;
  logic              dir_q, phase_q, depset_q;
  logic [2:0]        status_q;
  logic              out_valid_q;
  dsws_pkg::dsws_out_t out_q;

  logic [XW-1:0] top_x, bot_x, flr_x, lvl_x, cnt_x, snp_x, m_x, p_x, e_x, i_x;
  logic [XW-1:0] sw_x, d_x, lv_x, room_x, n_x, k_x, rd_x, addr_x, sh_x;
  logic [CW-1:0] rd_c, p_c, bot_c;
  logic          peek_ok, speek_ok, find_mode;
  logic [ENTRY_BITS+31:0] val_ext, dat_ext;
  logic [XW+10:0]        dep_ext;

  assign top_x  = XW'(top_q);
  assign bot_x  = XW'(bot_q);
  assign flr_x  = XW'(flr_q);
  assign lvl_x  = XW'(lvl_q);
  assign cnt_x  = XW'(cnt_q);
  assign snp_x  = XW'(snp_q);
  assign m_x    = XW'(m_q);
  assign p_x    = XW'(p_q);
  assign e_x    = XW'(prev_q);
  assign i_x    = XW'(i_q);
  assign sw_x   = XW'(STACK_WORDS);
  assign d_x    = top_x - flr_x;
  assign lv_x   = top_x - bot_x;
  assign room_x = sw_x - top_x;
  assign n_x    = (cnt_x < lv_x) ? cnt_x : lv_x;
  assign k_x    = lv_x - n_x;
  assign sh_x   = e_x - p_x;
  assign rd_x   = XW'(mem_rdata_i);
  assign rd_c   = CW'(mem_rdata_i);
  assign p_c    = CW'(p_q);
  assign bot_c  = CW'(bot_q);

  assign peek_ok   = (lvl_q != '0) && (lvl_x <= d_x);
  assign speek_ok  = (lvl_q != '0) && (lvl_x <= m_x);
  assign find_mode = (op_q != dsws_pkg::OP_SNAP_CNT);

  assign val_ext = {{ENTRY_BITS{1'b0}}, in_data_i.value};
  assign dat_ext = {32'd0, data_q};
  assign dep_ext = depset_q ? (XW+11)'(dep_q) : (XW+11)'(top_x - flr_x);

  // memory request, decoded from the same conditions as the sequencer
  always_comb begin
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    addr_x      = '0;
    mem_wdata_o = '0;
    case (state_q)
      S_EXEC: begin
        case (op_q)
          dsws_pkg::OP_PUSH: begin
            mem_we_o    = (room_x != '0);
            addr_x      = top_x;
            mem_wdata_o = val_q;
          end
          dsws_pkg::OP_POP: begin
            mem_re_o = (d_x != '0);
            addr_x   = top_x - 1'b1;
          end
          dsws_pkg::OP_PEEK: begin
            mem_re_o = peek_ok;
            addr_x   = top_x - lvl_x;
          end
          dsws_pkg::OP_OVERWRITE: begin
            mem_we_o    = peek_ok;
            addr_x      = top_x - lvl_x;
            mem_wdata_o = val_q;
          end
          dsws_pkg::OP_SNAP_FULL: begin
            mem_we_o    = (lv_x + 1'b1 <= room_x);
            addr_x      = top_x;
            mem_wdata_o = ENTRY_BITS'(lv_x);
          end
          dsws_pkg::OP_SNAP_KEEP: begin
            mem_we_o    = (n_x + 1'b1 <= room_x);
            addr_x      = top_x;
            mem_wdata_o = ENTRY_BITS'(lv_x);
          end
          dsws_pkg::OP_SNAP_CLR: begin
            mem_we_o    = (room_x != '0);
            addr_x      = top_x;
            mem_wdata_o = ENTRY_BITS'(lv_x);
          end
          dsws_pkg::OP_DROP_CUR: begin
            mem_re_o = (bot_q != '0);
            addr_x   = bot_x - 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_WALK_RD: begin
        mem_re_o = (p_q != '0);
        addr_x   = p_x - 1'b1;
      end
      S_FOUND: begin
        mem_re_o = (op_q == dsws_pkg::OP_SNAP_PEEK) && speek_ok;
        addr_x   = e_x - lvl_x - 1'b1;
      end
      S_CP_RD: begin
        mem_re_o = (len_q != '0);
        addr_x   = XW'(src_q);
      end
      S_CP_WR: begin
        mem_we_o    = 1'b1;
        addr_x      = XW'(dst_q);
        mem_wdata_o = mem_rdata_i;
      end
      S_MARK: begin
        mem_we_o    = 1'b1;
        addr_x      = top_x - n_x;
        mem_wdata_o = ENTRY_BITS'(k_x);
      end
      default: begin
      end
    endcase
  end

  assign mem_addr_o = addr_x[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      bot_q       <= '0;
      flr_q       <= '0;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      depset_q    <= 1'b0;
      dir_q       <= 1'b0;
    end else begin
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q     <= in_data_i.op;
            val_q    <= val_ext[ENTRY_BITS-1:0];
            lvl_q    <= in_data_i.level;
            cnt_q    <= in_data_i.count;
            snp_q    <= in_data_i.snapshot;
            status_q <= dsws_pkg::ST_OK;
            data_q   <= '0;
            dep_q    <= '0;
            depset_q <= 1'b0;
            phase_q  <= 1'b0;
            state_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_DONE;
          p_q     <= bot_q;
          i_q     <= '0;
          dir_q   <= 1'b0;
          case (op_q)
            dsws_pkg::OP_PUSH: begin
              if (room_x == '0) status_q <= dsws_pkg::ST_FULL;
              else top_q <= top_q + 1'b1;
            end
            dsws_pkg::OP_POP: begin
              if (d_x == '0) status_q <= dsws_pkg::ST_EMPTY;
              else state_q <= S_RDWAIT;
            end
            dsws_pkg::OP_DROP: begin
              if (cnt_x > d_x) status_q <= dsws_pkg::ST_EMPTY;
              else top_q <= IW'(top_x - cnt_x);
            end
            dsws_pkg::OP_REMOVE: begin
              if (lvl_q == '0) begin
                status_q <= dsws_pkg::ST_RANGE;
              end else if (lvl_x + cnt_x - 1'b1 > d_x) begin
                status_q <= dsws_pkg::ST_EMPTY;
              end else if (lvl_q > 10'd1 && cnt_q != '0) begin
                src_q   <= IW'(top_x - lvl_x + 1'b1);
                dst_q   <= IW'(top_x - lvl_x - cnt_x + 1'b1);
                len_q   <= IW'(lvl_x - 1'b1);
                state_q <= S_CP_RD;
              end else begin
                top_q <= IW'(top_x - cnt_x);
              end
            end
            dsws_pkg::OP_PEEK: begin
              if (peek_ok) state_q <= S_RDWAIT;
              else status_q <= dsws_pkg::ST_RANGE;
            end
            dsws_pkg::OP_OVERWRITE: begin
              if (!peek_ok) status_q <= dsws_pkg::ST_RANGE;
            end
            dsws_pkg::OP_CLEAR:     top_q <= flr_q;
            dsws_pkg::OP_PROTECT:   flr_q <= top_q;
            dsws_pkg::OP_UNPROTECT: flr_q <= bot_q;
            dsws_pkg::OP_SNAP_FULL: begin
              if (lv_x + 1'b1 > room_x) begin
                status_q <= dsws_pkg::ST_FULL;
              end else begin
                src_q   <= bot_q;
                dst_q   <= top_q + 1'b1;
                len_q   <= IW'(lv_x);
                state_q <= S_CP_RD;
              end
            end
            dsws_pkg::OP_SNAP_KEEP: begin
              if (n_x + 1'b1 > room_x) begin
                status_q <= dsws_pkg::ST_FULL;
              end else begin
                src_q   <= IW'(top_x - n_x);
                dst_q   <= top_q + 1'b1;
                len_q   <= IW'(n_x);
                state_q <= S_CP_RD;
              end
            end
            dsws_pkg::OP_SNAP_HIDE: begin
              if (k_x + 1'b1 > room_x) begin
                status_q <= dsws_pkg::ST_FULL;
              end else begin
                // hidden levels move up by k+1, top word first
                dir_q   <= 1'b1;
                src_q   <= top_q - 1'b1;
                dst_q   <= IW'(top_x + k_x);
                len_q   <= IW'(n_x);
                state_q <= S_CP_RD;
              end
            end
            dsws_pkg::OP_SNAP_CLR: begin
              if (room_x == '0) begin
                status_q <= dsws_pkg::ST_FULL;
              end else begin
                top_q <= top_q + 1'b1;
                bot_q <= top_q + 1'b1;
                flr_q <= top_q + 1'b1;
              end
            end
            dsws_pkg::OP_RESTORE, dsws_pkg::OP_REVERT: begin
              if (flr_q != bot_q) status_q <= dsws_pkg::ST_PROT;
              else state_q <= (snp_q == '0) ? S_WEND : S_WALK_RD;
            end
            dsws_pkg::OP_SNAP_REM, dsws_pkg::OP_SNAP_DEP, dsws_pkg::OP_SNAP_PEEK: begin
              state_q <= (snp_q == '0) ? S_WEND : S_WALK_RD;
            end
            dsws_pkg::OP_SNAP_CNT: state_q <= S_WALK_RD;
            dsws_pkg::OP_DROP_CUR: begin
              if (bot_q != '0) begin
                state_q <= S_RD17;
              end else begin
                top_q <= '0;
                bot_q <= '0;
                flr_q <= '0;
              end
            end
            default: begin
            end
          endcase
        end
        S_RDWAIT: begin
          data_q <= mem_rdata_i;
          if (op_q == dsws_pkg::OP_POP) top_q <= top_q - 1'b1;
          state_q <= S_DONE;
        end
        S_RD17: begin
          if (rd_c < bot_c) begin
            top_q <= bot_q - 1'b1;
            bot_q <= IW'(bot_x - rd_x - 1'b1);
            if (flr_x - rd_x - 1'b1 > bot_x - 1'b1) flr_q <= bot_q - 1'b1;
            else flr_q <= IW'(flr_x - rd_x - 1'b1);
          end else begin
            top_q <= '0;
            bot_q <= '0;
            flr_q <= '0;
          end
          state_q <= S_DONE;
        end
        S_WALK_RD: begin
          state_q <= (p_q == '0) ? S_WEND : S_WALK_CHK;
        end
        S_WALK_CHK: begin
          if (rd_c >= p_c) begin
            state_q <= S_WEND;
          end else begin
            m_q    <= IW'(rd_x);
            prev_q <= p_q;
            p_q    <= IW'(p_x - rd_x - 1'b1);
            i_q    <= i_q + 1'b1;
            if (find_mode && (i_x + 1'b1 == snp_x)) state_q <= S_FOUND;
            else state_q <= S_WALK_RD;
          end
        end
        S_WEND: begin
          if (!find_mode) begin
            dep_q    <= i_q;
            depset_q <= 1'b1;
          end else begin
            status_q <= dsws_pkg::ST_BADSNAP;
            if (op_q == dsws_pkg::OP_SNAP_DEP) depset_q <= 1'b1;
          end
          state_q <= S_DONE;
        end
        S_FOUND: begin
          state_q <= S_DONE;
          case (op_q)
            dsws_pkg::OP_RESTORE, dsws_pkg::OP_REVERT: begin
              if (m_x > sw_x - bot_x) begin
                status_q <= dsws_pkg::ST_FULL;
              end else begin
                src_q   <= p_q;
                dst_q   <= bot_q;
                len_q   <= m_q;
                state_q <= S_CP_RD;
              end
            end
            dsws_pkg::OP_SNAP_REM: state_q <= S_REMOVE;
            dsws_pkg::OP_SNAP_DEP: begin
              dep_q    <= m_q;
              depset_q <= 1'b1;
            end
            dsws_pkg::OP_SNAP_PEEK: begin
              if (speek_ok) state_q <= S_RDWAIT;
              else status_q <= dsws_pkg::ST_RANGE;
            end
            default: begin
            end
          endcase
        end
        S_REMOVE: begin
          // close the gap left by the snapshot and its marker
          src_q   <= prev_q;
          dst_q   <= p_q;
          len_q   <= (top_q > prev_q) ? (top_q - prev_q) : '0;
          dir_q   <= 1'b0;
          phase_q <= 1'b1;
          state_q <= S_CP_RD;
        end
        S_CP_RD: begin
          state_q <= (len_q == '0) ? S_POST : S_CP_WR;
        end
        S_CP_WR: begin
          src_q   <= dir_q ? (src_q - 1'b1) : (src_q + 1'b1);
          dst_q   <= dir_q ? (dst_q - 1'b1) : (dst_q + 1'b1);
          len_q   <= len_q - 1'b1;
          state_q <= S_CP_RD;
        end
        S_MARK: begin
          src_q   <= bot_q;
          dst_q   <= IW'(top_x - n_x + 1'b1);
          len_q   <= IW'(k_x);
          dir_q   <= 1'b0;
          phase_q <= 1'b1;
          state_q <= S_CP_RD;
        end
        S_POST: begin
          state_q <= S_DONE;
          case (op_q)
            dsws_pkg::OP_REMOVE: top_q <= IW'(top_x - cnt_x);
            dsws_pkg::OP_SNAP_FULL: begin
              top_q <= IW'(top_x + lv_x + 1'b1);
              bot_q <= IW'(bot_x + lv_x + 1'b1);
              flr_q <= IW'(flr_x + lv_x + 1'b1);
            end
            dsws_pkg::OP_SNAP_KEEP: begin
              top_q <= IW'(top_x + n_x + 1'b1);
              bot_q <= top_q + 1'b1;
              if (flr_x + lv_x > top_x + n_x) flr_q <= IW'(top_x + n_x + 1'b1);
              else flr_q <= IW'(flr_x + lv_x + 1'b1);
            end
            dsws_pkg::OP_SNAP_HIDE: begin
              if (!phase_q) begin
                state_q <= S_MARK;
              end else begin
                top_q <= IW'(top_x + k_x + 1'b1);
                bot_q <= IW'(bot_x + k_x + 1'b1);
                flr_q <= IW'(flr_x + k_x + 1'b1);
              end
            end
            dsws_pkg::OP_RESTORE: begin
              top_q <= bot_q + m_q;
              flr_q <= bot_q;
            end
            dsws_pkg::OP_REVERT: begin
              if (!phase_q) begin
                top_q   <= bot_q + m_q;
                flr_q   <= bot_q;
                state_q <= S_REMOVE;
              end else begin
                top_q <= IW'(top_x - sh_x);
                bot_q <= IW'(bot_x - sh_x);
                flr_q <= IW'(flr_x - sh_x);
              end
            end
            dsws_pkg::OP_SNAP_REM: begin
              top_q <= IW'(top_x - sh_x);
              bot_q <= IW'(bot_x - sh_x);
              flr_q <= IW'(flr_x - sh_x);
            end
            default: begin
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.data   <= dat_ext[31:0];
            out_q.depth  <= dep_ext[10:0];
            out_q.status <= status_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/data_stack_with_snapshots_top.sv */
// Channel   Direction  Valid/stall             Payload
// in        input      in_valid_i/in_stall_o   in_data_i   (dsws_in_t)
// out       output     out_valid_o/out_stall_i out_data_o  (dsws_out_t)
//
// One transaction at a time through a sequencer over a single-port stack memory.
// Simple ops pass execute and done states, reads add a read-wait state; snapshot
// lookups read then check each marker walked; copies read then write each word.
// Reset clears the indices only; the memory is not cleared.
// A stalled result holds the next transaction in its final state until it is taken.
module data_stack_with_snapshots_top #(
  parameter int unsigned STACK_WORDS = dsws_pkg::STACK_WORDS,
  parameter int unsigned ENTRY_BITS  = dsws_pkg::ENTRY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dsws_pkg::dsws_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dsws_pkg::dsws_out_t out_data_o
);

  logic                           mem_we, mem_re;
  logic [$clog2(STACK_WORDS)-1:0] mem_addr;
  logic [ENTRY_BITS-1:0]          mem_wdata, mem_rdata;

  dsws_ctrl #(
    .STACK_WORDS(STACK_WORDS),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .mem_rdata_i(mem_rdata)
  );

  dsws_mem #(
    .DEPTH(STACK_WORDS),
    .WIDTH(ENTRY_BITS)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

endmodule

/* design/dsws_chk.sv */
module dsws_chk (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input dsws_pkg::dsws_out_t out_data_o
);

  // an accepted transaction makes the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted back to back");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= dsws_pkg::ST_RANGE)
    else $error("status code out of range");

  // failed operations never return a word
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != dsws_pkg::ST_OK) |-> out_data_o.data == '0)
    else $error("data on failed operation");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind data_stack_with_snapshots_top dsws_chk u_dsws_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
